FILE: hdl/lsb_pkg.sv
// Shared types and constants for the lock semaphore bank.
// Payload structs, the decoded command struct and the address map.
// No dependencies.
package lsb_pkg;

   localparam int LockCount   = 16;
   localparam int RequestBase = 262144;
   localparam int ValueBase   = 126976;

   localparam int LockStride  = 'h400;
   localparam int ValStride   = 'h10;
   localparam int LockIdxW    = (LockCount > 1) ? $clog2(LockCount) : 1;
   localparam int CntW        = 6;
   localparam int ReqW        = 7;

   // address compares are made one bit wider than the bus so the upper bound cannot wrap
   localparam logic [20:0] ReqLo = 21'(RequestBase);
   localparam logic [20:0] ReqHi = 21'(RequestBase + LockCount * LockStride);
   localparam logic [20:0] ValLo = 21'(ValueBase);
   localparam logic [20:0] ValHi = 21'(ValueBase + LockCount * ValStride);

   typedef struct packed {
      logic        func;
      logic [19:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [CntW-1:0] read_data;
      logic            mapped;
      logic            error;
   } rsp_type;

   typedef enum logic [5:0] {
      OP_NONE    = 6'b000001,
      OP_REQ_ERR = 6'b000010,
      OP_ACQ     = 6'b000100,
      OP_REL     = 6'b001000,
      OP_VRD     = 6'b010000,
      OP_VWR     = 6'b100000
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [LockIdxW-1:0] idx;
      logic [ReqW-1:0]     val;   // signed request value, two's complement
      logic [CntW-1:0]     wval;
   } cmd_type;

endpackage

FILE: hdl/lsb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lsb_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lsb_decode.sv
// Address decoder: turns one bus beat into a lock command.
// Depends on lsb_pkg.
module lsb_decode (
   input  lsb_pkg::req_type req,
   output lsb_pkg::cmd_type cmd
);

   logic [20:0] addr_ext;
   logic [20:0] req_rel;
   logic [20:0] val_rel;
   logic        in_req;
   logic        in_val;

   always_comb begin
      addr_ext = {1'b0, req.address};
      req_rel  = addr_ext - lsb_pkg::ReqLo;
      val_rel  = addr_ext - lsb_pkg::ValLo;
      in_req   = (addr_ext >= lsb_pkg::ReqLo) && (addr_ext < lsb_pkg::ReqHi);
      in_val   = (addr_ext >= lsb_pkg::ValLo) && (addr_ext < lsb_pkg::ValHi)
                 && (val_rel[3:2] == 2'b00);

      cmd.wval = req.write_data[lsb_pkg::CntW-1:0];
      // subtracting 0x40000 leaves bits 8:2 of the offset untouched
      cmd.val  = req_rel[8:2];
      cmd.idx  = val_rel[lsb_pkg::LockIdxW+3:4];
      cmd.op   = lsb_pkg::OP_NONE;

      if (in_req) begin
         cmd.idx = req_rel[lsb_pkg::LockIdxW+9:10];
         if (req.func) begin
            cmd.op = lsb_pkg::OP_REQ_ERR;
         end else if (req_rel[9]) begin
            cmd.op = lsb_pkg::OP_ACQ;
         end else begin
            cmd.op = lsb_pkg::OP_REL;
         end
      end else if (in_val) begin
         cmd.op = req.func ? lsb_pkg::OP_VWR : lsb_pkg::OP_VRD;
      end
   end

endmodule

FILE: hdl/lock_semaphore_bank.sv
// Lock semaphore bank: counting-semaphore counters held in one RAM.
// The accepted beat and its RAM read are registered in stage s1, then the result beat is registered at the ports.
// Busy covers the RAM read-modify-write in stage s1; no new beat is accepted while it is high.
// Reset: synchronous; clears control and the per-lock valid bits, so all
// counters read as zero right after reset with no clearing pass.
// Depends on lsb_pkg, lsb_decode, lsb_ram.
module lock_semaphore_bank (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lsb_pkg::req_type req_data,
   output logic             rsp_valid,
   output lsb_pkg::rsp_type rsp_data
);

   lsb_pkg::cmd_type              dec_cmd;
   lsb_pkg::cmd_type              s1_cmd_ff;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [lsb_pkg::LockCount-1:0] cnt_valid_ff;
   logic [lsb_pkg::LockCount-1:0] cnt_valid_in;
   logic [lsb_pkg::CntW-1:0]      ram_q;
   logic [lsb_pkg::CntW-1:0]      cnt;
   logic [lsb_pkg::CntW-1:0]      cnt_new;
   logic [lsb_pkg::ReqW-1:0]      mag;
   logic                          wr_en;
   logic                          accept;
   logic                          rsp_valid_ff;
   lsb_pkg::rsp_type              rsp_ff;
   lsb_pkg::rsp_type              rsp_in;

   lsb_decode u_decode (
      .req (req_data),
      .cmd (dec_cmd)
   );

   assign accept = start && !s1_valid_ff;

   lsb_ram #(
      .Width (lsb_pkg::CntW),
      .Depth (lsb_pkg::LockCount)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_cmd_ff.idx),
      .wr_data (cnt_new),
      .rd_en   (accept),
      .rd_addr (dec_cmd.idx),
      .rd_data (ram_q)
   );

   always_comb begin
      cnt     = cnt_valid_ff[s1_cmd_ff.idx] ? ram_q : '0;
      mag     = -s1_cmd_ff.val;
      cnt_new = cnt;
      wr_en   = 1'b0;
      rsp_in  = '0;
      unique case (s1_cmd_ff.op)
         lsb_pkg::OP_NONE: begin
         end
         lsb_pkg::OP_REQ_ERR: begin
            rsp_in.mapped = 1'b1;
            rsp_in.error  = 1'b1;
         end
         lsb_pkg::OP_ACQ: begin
            rsp_in.mapped = 1'b1;
            if (!s1_cmd_ff.val[lsb_pkg::ReqW-1]) begin
               // exact match drains the counter to zero
               if (cnt == s1_cmd_ff.val[lsb_pkg::CntW-1:0]) begin
                  rsp_in.read_data = lsb_pkg::CntW'(1);
                  cnt_new          = '0;
                  wr_en            = 1'b1;
               end
            end else if ({1'b0, cnt} >= mag) begin
               rsp_in.read_data = lsb_pkg::CntW'(1);
               cnt_new          = cnt - mag[lsb_pkg::CntW-1:0];
               wr_en            = 1'b1;
            end
         end
         lsb_pkg::OP_REL: begin
            rsp_in.mapped    = 1'b1;
            rsp_in.read_data = lsb_pkg::CntW'(1);
            cnt_new          = cnt + s1_cmd_ff.val[lsb_pkg::CntW-1:0];
            wr_en            = 1'b1;
         end
         lsb_pkg::OP_VRD: begin
            rsp_in.mapped    = 1'b1;
            rsp_in.read_data = cnt;
         end
         lsb_pkg::OP_VWR: begin
            rsp_in.mapped = 1'b1;
            cnt_new       = s1_cmd_ff.wval;
            wr_en         = 1'b1;
         end
         default: begin
         end
      endcase
      wr_en = wr_en && s1_valid_ff;
   end

   always_comb begin
      s1_valid_in  = accept;
      cnt_valid_in = cnt_valid_ff;
      if (wr_en) begin
         cnt_valid_in[s1_cmd_ff.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= s1_valid_ff;
         cnt_valid_ff <= cnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= dec_cmd;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = s1_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/lsb_checker.sv
// Port-level checks on the lock semaphore bank, bound to the top level.
// Depends on lsb_pkg and lock_semaphore_bank.
module lsb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input lsb_pkg::req_type req_data,
   input logic             rsp_valid,
   input lsb_pkg::rsp_type rsp_data
);

   // an accepted beat holds the bank for exactly one cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("missing result beat");

   a_no_stray_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a request");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.mapped && (rsp_data.read_data == '0))
      else $error("error beat with bad fields");

endmodule

bind lock_semaphore_bank lsb_checker u_lsb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
